FILE: rtl/wmlm_pkg.sv
package wmlm_pkg;

  // fixed field widths of the payload
  localparam int unsigned NUM_FIELDS    = 10;
  localparam int unsigned SAMPLE_BITS   = 16;
  localparam int unsigned LIMIT_BITS    = 16;
  localparam int unsigned CNT_BITS      = 32;
  localparam int unsigned CH_OUT_BITS   = 4;
  localparam int unsigned THR_BITS      = 4;
  localparam int unsigned CFG_IDX_BITS  = 3;
  localparam int unsigned CFG_DATA_BITS = 64;

  // parameter defaults
  localparam int unsigned DEF_CHANNELS = 10;
  localparam int unsigned DEF_WINDOW   = 5;

  // register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_LIMITS_BASE = 3'd1;

  // limit register layout within one channel pair
  localparam int unsigned LIMIT_ODD_OFS = 32;
  localparam int unsigned LIMIT_MAX_OFS = 16;

  localparam logic signed [LIMIT_BITS-1:0] LIMIT_MIN_RESET = 16'sh8000;
  localparam logic signed [LIMIT_BITS-1:0] LIMIT_MAX_RESET = 16'sh7FFF;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_9;
    logic signed [SAMPLE_BITS-1:0] sample_8;
    logic signed [SAMPLE_BITS-1:0] sample_7;
    logic signed [SAMPLE_BITS-1:0] sample_6;
    logic signed [SAMPLE_BITS-1:0] sample_5;
    logic signed [SAMPLE_BITS-1:0] sample_4;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_0;
  } in_t;

  typedef struct packed {
    logic [CNT_BITS-1:0]    anomaly_total;
    logic                   anomaly;
    logic [CH_OUT_BITS-1:0] channels_out;
    logic                   window_full;
    logic [CNT_BITS-1:0]    row_number;
  } out_t;

  // sample of one channel, by constant index
  function automatic logic [SAMPLE_BITS-1:0] sample_at(in_t d, int unsigned idx);
    logic [SAMPLE_BITS-1:0] s;
    case (idx)
      0:       s = d.sample_0;
      1:       s = d.sample_1;
      2:       s = d.sample_2;
      3:       s = d.sample_3;
      4:       s = d.sample_4;
      5:       s = d.sample_5;
      6:       s = d.sample_6;
      7:       s = d.sample_7;
      8:       s = d.sample_8;
      9:       s = d.sample_9;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/wmlm_cfg.sv
module wmlm_cfg #(
  parameter int unsigned CHANNELS = wmlm_pkg::DEF_CHANNELS,
  parameter int unsigned WINDOW   = wmlm_pkg::DEF_WINDOW,
  localparam int unsigned SUM_W   = wmlm_pkg::SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [wmlm_pkg::CFG_IDX_BITS-1:0]      cfg_index_i,
  input  logic [wmlm_pkg::CFG_DATA_BITS-1:0]     cfg_data_i,
  output logic [wmlm_pkg::THR_BITS-1:0]          thr_o,
  output logic signed [SUM_W-1:0]                lim_lo_o [CHANNELS],
  output logic signed [SUM_W-1:0]                lim_hi_o [CHANNELS]
);

  localparam logic signed [SUM_W-1:0] SCALE    = SUM_W'(WINDOW);
  localparam logic signed [SUM_W-1:0] RESET_LO = SUM_W'(wmlm_pkg::LIMIT_MIN_RESET) * SCALE;
  localparam logic signed [SUM_W-1:0] RESET_HI = SUM_W'(wmlm_pkg::LIMIT_MAX_RESET) * SCALE;

  logic [wmlm_pkg::THR_BITS-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (cfg_we_i && cfg_index_i == wmlm_pkg::REG_THRESHOLD) begin
      thr_q <= cfg_data_i[wmlm_pkg::THR_BITS-1:0];
    end
  end

  assign thr_o = thr_q;

  // limits are kept already scaled by the window length
  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_lim
    localparam int unsigned MIN_LSB = (ch % 2) * wmlm_pkg::LIMIT_ODD_OFS;
    localparam int unsigned MAX_LSB = MIN_LSB + wmlm_pkg::LIMIT_MAX_OFS;
    localparam logic [wmlm_pkg::CFG_IDX_BITS-1:0] IDX =
      wmlm_pkg::REG_LIMITS_BASE + wmlm_pkg::CFG_IDX_BITS'(ch / 2);

    logic signed [wmlm_pkg::LIMIT_BITS-1:0] wr_min;
    logic signed [wmlm_pkg::LIMIT_BITS-1:0] wr_max;
    logic signed [SUM_W-1:0]                lo_q;
    logic signed [SUM_W-1:0]                hi_q;

    assign wr_min = $signed(cfg_data_i[MIN_LSB +: wmlm_pkg::LIMIT_BITS]);
    assign wr_max = $signed(cfg_data_i[MAX_LSB +: wmlm_pkg::LIMIT_BITS]);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        lo_q <= RESET_LO;
        hi_q <= RESET_HI;
      end else if (cfg_we_i && cfg_index_i == IDX) begin
        lo_q <= SUM_W'(wr_min) * SCALE;
        hi_q <= SUM_W'(wr_max) * SCALE;
      end
    end

    assign lim_lo_o[ch] = lo_q;
    assign lim_hi_o[ch] = hi_q;
  end

endmodule

FILE: rtl/wmlm_accum.sv
module wmlm_accum #(
  parameter int unsigned CHANNELS = wmlm_pkg::DEF_CHANNELS,
  parameter int unsigned WINDOW   = wmlm_pkg::DEF_WINDOW,
  localparam int unsigned SUM_W   = wmlm_pkg::SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                acc_en_i,
  input  wmlm_pkg::in_t                       in_data_i,
  output logic signed [SUM_W-1:0]             sum_o [CHANNELS],
  output logic [wmlm_pkg::CNT_BITS-1:0]       row_count_o,
  output logic                                full_o
);

  localparam int unsigned SB     = wmlm_pkg::SAMPLE_BITS;
  localparam int unsigned SLOT_W = $clog2(WINDOW);
  localparam int unsigned ROW_W  = CHANNELS * SB;

  logic [ROW_W-1:0] mem [WINDOW];
  logic [ROW_W-1:0] rd_q;
  logic [ROW_W-1:0] wr_row;

  logic [SLOT_W-1:0]             slot_q, slot_d;
  logic                          full_q;
  logic [wmlm_pkg::CNT_BITS-1:0] row_q;
  logic signed [SUM_W-1:0]       sum_q [CHANNELS];
  logic signed [SUM_W-1:0]       sum_d [CHANNELS];

  assign slot_d = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);

  for (genvar ch = 0; ch < CHANNELS; ch++) begin : g_ch
    logic signed [SB-1:0]    nw;
    logic signed [SB-1:0]    od;
    logic signed [SUM_W-1:0] od_x;

    assign nw = $signed(wmlm_pkg::sample_at(in_data_i, ch));
    assign od = $signed(rd_q[ch*SB +: SB]);
    assign wr_row[ch*SB +: SB] = nw;
    // oldest row leaves the sum only once the ring has wrapped
    assign od_x = full_q ? SUM_W'(od) : '0;
    assign sum_d[ch] = sum_q[ch] - od_x + SUM_W'(nw);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
      row_q  <= '0;
      for (int i = 0; i < CHANNELS; i++) begin
        sum_q[i] <= '0;
      end
    end else if (acc_en_i) begin
      slot_q <= slot_d;
      full_q <= full_q | (slot_q == SLOT_W'(WINDOW - 1));
      if (row_q != wmlm_pkg::CNT_MAX) begin
        row_q <= row_q + wmlm_pkg::CNT_BITS'(1);
      end
      sum_q <= sum_d;
    end
  end

  // ring of rows; the read port prefetches the row the next transfer replaces
  always_ff @(posedge clk_i) begin
    if (acc_en_i) begin
      mem[slot_q] <= wr_row;
      rd_q        <= mem[slot_d];
    end
  end

  assign sum_o       = sum_q;
  assign row_count_o = row_q;
  assign full_o      = full_q;

endmodule

FILE: rtl/wmlm_judge.sv
module wmlm_judge #(
  parameter int unsigned CHANNELS = wmlm_pkg::DEF_CHANNELS,
  parameter int unsigned WINDOW   = wmlm_pkg::DEF_WINDOW,
  localparam int unsigned SUM_W   = wmlm_pkg::SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            load_i,
  input  logic signed [SUM_W-1:0]         sum_i [CHANNELS],
  input  logic signed [SUM_W-1:0]         lim_lo_i [CHANNELS],
  input  logic signed [SUM_W-1:0]         lim_hi_i [CHANNELS],
  input  logic [wmlm_pkg::THR_BITS-1:0]   thr_i,
  input  logic [wmlm_pkg::CNT_BITS-1:0]   row_count_i,
  input  logic                            full_i,
  output wmlm_pkg::out_t                  out_o
);

  localparam int unsigned CNT_W = $clog2(CHANNELS + 1);

  logic [CNT_W-1:0]                 cnt;
  logic [wmlm_pkg::CH_OUT_BITS-1:0] chan_out;
  logic                             anomaly;
  logic [wmlm_pkg::CNT_BITS-1:0]    total_q, total_d;
  wmlm_pkg::out_t                   out_q;

  always_comb begin
    cnt = '0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      if (sum_i[ch] < lim_lo_i[ch] || sum_i[ch] > lim_hi_i[ch]) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  assign chan_out = full_i ? wmlm_pkg::CH_OUT_BITS'(cnt) : '0;
  assign anomaly  = full_i && (chan_out > thr_i);
  assign total_d  = (anomaly && total_q != wmlm_pkg::CNT_MAX) ?
                    total_q + wmlm_pkg::CNT_BITS'(1) : total_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (load_i) begin
      total_q <= total_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      out_q.row_number    <= row_count_i;
      out_q.window_full   <= full_i;
      out_q.channels_out  <= chan_out;
      out_q.anomaly       <= anomaly;
      out_q.anomaly_total <= total_d;
    end
  end

  assign out_o = out_q;

endmodule

FILE: rtl/windowed_mean_limit_monitor_core.sv
// an input row passes the stage 1 sum registers and then the stage 2
//   result register before out_valid_o rises
// throughput: one row per cycle unless out_ready_i holds stage 2 back,
//   set by the running-sum update and the limit compare stage behind it
// reset: control, counters, sums, threshold and limits reset at once;
//   the row ring is not cleared; its rows only enter the sums once written
module windowed_mean_limit_monitor_core #(
  parameter int unsigned CHANNELS = wmlm_pkg::DEF_CHANNELS,
  parameter int unsigned WINDOW   = wmlm_pkg::DEF_WINDOW,
  localparam int unsigned SUM_W   = wmlm_pkg::SAMPLE_BITS + $clog2(WINDOW)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // sample rows
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  wmlm_pkg::in_t                      in_data_i,
  // results
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output wmlm_pkg::out_t                     out_data_o,
  // register writes
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wmlm_pkg::CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [wmlm_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  // stage 1: running sums and counters (in the accumulator)
  // stage 2: limit compare and anomaly count, into the result register
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_go;
  logic in_xfer;

  logic [wmlm_pkg::THR_BITS-1:0] thr;
  logic signed [SUM_W-1:0]       lim_lo [CHANNELS];
  logic signed [SUM_W-1:0]       lim_hi [CHANNELS];
  logic signed [SUM_W-1:0]       sum [CHANNELS];
  logic [wmlm_pkg::CNT_BITS-1:0] row_count;
  logic                          full;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  // stage 1 moves on when the result register is empty or being drained
  assign s1_go      = !out_valid_q || out_ready_i;
  // a new row may enter while stage 1 hands its row on in the same cycle
  assign in_ready_o = !s1_valid_q || s1_go;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_valid_q && s1_go) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;

  wmlm_cfg #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .thr_o       (thr),
    .lim_lo_o    (lim_lo),
    .lim_hi_o    (lim_hi)
  );

  // the sum registers hold the row in stage 1; a row entering on the same
  // edge that stage 2 samples them overwrites them only after that sample
  wmlm_accum #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_en_i    (in_xfer),
    .in_data_i   (in_data_i),
    .sum_o       (sum),
    .row_count_o (row_count),
    .full_o      (full)
  );

  wmlm_judge #(
    .CHANNELS (CHANNELS),
    .WINDOW   (WINDOW)
  ) u_judge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (s1_valid_q && s1_go),
    .sum_i       (sum),
    .lim_lo_i    (lim_lo),
    .lim_hi_i    (lim_hi),
    .thr_i       (thr),
    .row_count_i (row_count),
    .full_i      (full),
    .out_o       (out_data_o)
  );

endmodule
